// File: sv/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants of the 3x3 mean box filter.
// ----------------------------------------------------------------------------
package bfm_pkg;

   // Channel bytes carried on the ports, and the width of one byte.
   localparam int CH_NUM = 3;
   localparam int PIX_W  = 8;

   // Sum of one window column (three bytes) and of the whole window (nine bytes).
   localparam int CSUM_W = 10;
   localparam int WSUM_W = 12;

   // floor(x / 9) is taken as (x * 7282) >> 16, which is exact for x below 32768.
   localparam int                 RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_NINE  = 13'd7282;
   localparam int                 RECIP_SHIFT = 16;

   // Row counter and the largest frame height.
   localparam int ROW_W      = 10;
   localparam int MAX_HEIGHT = 1024;

   // Register port.
   localparam int                   CSR_DATA_W        = 11;
   localparam int                   CSR_IDX_W         = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Result queue, counted in items.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_AW    = 3;

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_DRAIN = 1'b1
   } req_kind_type;

   // Control that travels with one item down the pipeline.
   typedef struct packed {
      logic valid;      // item pushes a column into the window
      logic drain;      // column comes from the line stores only
      logic fill;       // first column of a row: fill the whole window
      logic top_upper;  // top row comes from the upper line store
      logic emit_a;     // result centered on the middle window column
      logic emit_b;     // result at the right edge of the row
      logic last_b;     // edge result is the last of the frame
   } step_type;

   typedef logic [CH_NUM-1:0][PIX_W-1:0] mean_vec_type;

   typedef struct packed {
      mean_vec_type mean_a;
      mean_vec_type mean_b;
      logic         has_a;
      logic         has_b;
      logic         last_b;
   } rsp_entry_type;

endpackage

// File: sv/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bfm_seq.sv
// ----------------------------------------------------------------------------
// bfm_seq
// Stream position tracking, input handshake and the line store clearing pass.
// ----------------------------------------------------------------------------
module bfm_seq #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  bfm_pkg::req_kind_type         req_kind,
   output logic                          req_stall,
   input  logic [$clog2(MAX_WIDTH)-1:0]  width_last,
   input  logic [bfm_pkg::ROW_W-1:0]     height_last,
   input  logic                          queue_full,
   output bfm_pkg::step_type             issue,
   output logic [$clog2(MAX_WIDTH)-1:0]  issue_addr,
   output logic                          clear_en,
   output logic [$clog2(MAX_WIDTH)-1:0]  clear_addr
);
   import bfm_pkg::*;

   localparam int            AW        = $clog2(MAX_WIDTH);
   localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_WIDTH - 1);

   logic             clear_ff, clear_in;
   logic [AW-1:0]    clear_addr_ff, clear_addr_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [AW-1:0]    drain_col_ff, drain_col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             loaded_ff, loaded_in;

   logic             is_drain;
   logic [AW-1:0]    col;
   logic             row_end;
   logic             work;
   logic             rows_ok;
   logic             accept;

   assign req_stall  = clear_ff | queue_full;
   assign clear_en   = clear_ff;
   assign clear_addr = clear_addr_ff;
   assign issue_addr = col;

   // Pixels are taken only while a frame is being loaded, drain ticks only
   // once the whole frame is in; anything else is a transfer without effect.
   always_comb begin
      is_drain        = (req_kind == REQ_DRAIN);
      col             = is_drain ? drain_col_ff : col_ff;
      row_end         = (col >= width_last);
      work            = is_drain ? loaded_ff : !loaded_ff;
      rows_ok         = is_drain | (row_ff != '0);
      accept          = req_valid & !req_stall;
      issue.valid     = accept & work;
      issue.drain     = is_drain;
      issue.fill      = (col == '0);
      issue.top_upper = is_drain ? (row_ff != '0) : (row_ff >= ROW_W'(2));
      issue.emit_a    = accept & work & rows_ok & (col != '0);
      issue.emit_b    = accept & work & rows_ok & row_end;
      issue.last_b    = is_drain & row_end;
   end

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      col_in        = col_ff;
      drain_col_in  = drain_col_ff;
      row_in        = row_ff;
      loaded_in     = loaded_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == ADDR_LAST) begin
            clear_in = 1'b0;
         end
      end
      if (issue.valid) begin
         if (is_drain) begin
            if (row_end) begin
               loaded_in    = 1'b0;
               drain_col_in = '0;
               row_in       = '0;
               col_in       = '0;
            end else begin
               drain_col_in = col + AW'(1);
            end
         end else begin
            if (row_end) begin
               col_in = '0;
               if (row_ff >= height_last) begin
                  loaded_in    = 1'b1;
                  drain_col_in = '0;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         col_ff        <= '0;
         drain_col_ff  <= '0;
         row_ff        <= '0;
         loaded_ff     <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         col_ff        <= col_in;
         drain_col_ff  <= drain_col_in;
         row_ff        <= row_in;
         loaded_ff     <= loaded_in;
      end
   end

endmodule

// File: sv/bfm_line.sv
// ----------------------------------------------------------------------------
// bfm_line
// Line stores and the sliding window, kept as per-channel column sums.
// ----------------------------------------------------------------------------
module bfm_line #(
   parameter int MAX_WIDTH = 1024,
   parameter int NCH       = 3
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  bfm_pkg::step_type                                issue,
   input  logic [$clog2(MAX_WIDTH)-1:0]                     issue_addr,
   input  logic [NCH*bfm_pkg::PIX_W-1:0]                    issue_px,
   input  logic                                             clear_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]                     clear_addr,
   output bfm_pkg::step_type                                win_step,
   output logic [2:0][NCH-1:0][bfm_pkg::CSUM_W-1:0]         win_sum
);
   import bfm_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int LW = NCH * PIX_W;

   // Each store word holds the upper row above the lower row: {upper, lower}.
   step_type                         s1_step_ff;
   logic [AW-1:0]                    s1_addr_ff;
   logic [LW-1:0]                    s1_px_ff;
   logic                             s1_byp_ff, byp_in;
   logic [2*LW-1:0]                  s1_byp_data_ff;
   step_type                         win_step_ff;
   logic [2:0][NCH-1:0][CSUM_W-1:0]  win_ff, win_in;

   logic [2*LW-1:0]                  rd_data;
   logic [2*LW-1:0]                  line_cur;
   logic [LW-1:0]                    lower;
   logic [LW-1:0]                    upper;
   logic                             s1_wr;
   logic [2*LW-1:0]                  s1_wr_data;
   logic [NCH-1:0][CSUM_W-1:0]       col_sum;
   logic                             ram_wr_en;
   logic [AW-1:0]                    ram_wr_addr;
   logic [2*LW-1:0]                  ram_wr_data;

   // The store read for a new item happens at the same edge as the write of
   // the item ahead of it; with one-pixel rows both hit the same address, so
   // the written word is carried along in place of the stale read.
   always_comb begin
      s1_wr      = s1_step_ff.valid & !s1_step_ff.drain;
      line_cur   = s1_byp_ff ? s1_byp_data_ff : rd_data;
      lower      = line_cur[LW-1:0];
      upper      = line_cur[2*LW-1:LW];
      s1_wr_data = {lower, s1_px_ff};
      byp_in     = s1_wr & (s1_addr_ff == issue_addr);
   end

   always_comb begin
      ram_wr_en   = clear_en | s1_wr;
      ram_wr_addr = clear_en ? clear_addr : s1_addr_ff;
      ram_wr_data = clear_en ? '0 : s1_wr_data;
   end

   bfm_ram #(
      .WIDTH (2*LW),
      .DEPTH (MAX_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (issue_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [PIX_W-1:0] mid_px;
      logic [PIX_W-1:0] top_px;
      logic [PIX_W-1:0] bot_px;
      for (int k = 0; k < NCH; k++) begin
         mid_px     = lower[k*PIX_W +: PIX_W];
         top_px     = s1_step_ff.top_upper ? upper[k*PIX_W +: PIX_W] : mid_px;
         bot_px     = s1_step_ff.drain ? mid_px : s1_px_ff[k*PIX_W +: PIX_W];
         col_sum[k] = CSUM_W'(top_px) + CSUM_W'(mid_px) + CSUM_W'(bot_px);
      end
   end

   always_comb begin
      win_in = win_ff;
      if (s1_step_ff.valid) begin
         if (s1_step_ff.fill) begin
            win_in[0] = col_sum;
            win_in[1] = col_sum;
            win_in[2] = col_sum;
         end else begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = col_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_step_ff  <= '0;
         win_step_ff <= '0;
      end else begin
         s1_step_ff  <= issue;
         win_step_ff <= s1_step_ff;
      end
      s1_addr_ff     <= issue_addr;
      s1_px_ff       <= issue_px;
      s1_byp_ff      <= byp_in;
      s1_byp_data_ff <= s1_wr_data;
      win_ff         <= win_in;
   end

   assign win_step = win_step_ff;
   assign win_sum  = win_ff;

endmodule

// File: sv/bfm_mean.sv
// ----------------------------------------------------------------------------
// bfm_mean
// Window sums for the two result positions and the division by nine.
// ----------------------------------------------------------------------------
module bfm_mean #(
   parameter int NCH = 3
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  bfm_pkg::step_type                          win_step,
   input  logic [2:0][NCH-1:0][bfm_pkg::CSUM_W-1:0]   win_sum,
   input  logic [1:0]                                 chan_use,
   output logic                                       entry_valid,
   output bfm_pkg::rsp_entry_type                     entry
);
   import bfm_pkg::*;

   localparam int PW = WSUM_W + RECIP_W;

   step_type                    s3_step_ff;
   logic [NCH-1:0][WSUM_W-1:0]  s3_sum_a_ff, sum_a_in;
   logic [NCH-1:0][WSUM_W-1:0]  s3_sum_b_ff, sum_b_in;
   logic [PIX_W-1:0]            mean_a [CH_NUM];
   logic [PIX_W-1:0]            mean_b [CH_NUM];

   // The right-edge result repeats the last column in place of the one beyond.
   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         sum_a_in[k] = WSUM_W'(win_sum[0][k]) + WSUM_W'(win_sum[1][k]) +
                       WSUM_W'(win_sum[2][k]);
         sum_b_in[k] = WSUM_W'(win_sum[1][k]) + (WSUM_W'(win_sum[2][k]) << 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_step_ff <= '0;
      end else begin
         s3_step_ff <= win_step;
      end
      s3_sum_a_ff <= sum_a_in;
      s3_sum_b_ff <= sum_b_in;
   end

   for (genvar k = 0; k < CH_NUM; k++) begin : g_chan
      if (k < NCH) begin : g_used
         logic [PW-1:0] prod_a;
         logic [PW-1:0] prod_b;
         logic          on;
         assign prod_a = PW'(s3_sum_a_ff[k]) * PW'(RECIP_NINE);
         assign prod_b = PW'(s3_sum_b_ff[k]) * PW'(RECIP_NINE);
         assign on     = (2'(k) < chan_use);
         assign mean_a[k] = on ? prod_a[RECIP_SHIFT +: PIX_W] : '0;
         assign mean_b[k] = on ? prod_b[RECIP_SHIFT +: PIX_W] : '0;
      end else begin : g_unused
         assign mean_a[k] = '0;
         assign mean_b[k] = '0;
      end
   end

   always_comb begin
      for (int k = 0; k < CH_NUM; k++) begin
         entry.mean_a[k] = mean_a[k];
         entry.mean_b[k] = mean_b[k];
      end
      entry.has_a  = s3_step_ff.emit_a;
      entry.has_b  = s3_step_ff.emit_b;
      entry.last_b = s3_step_ff.last_b;
      entry_valid  = s3_step_ff.valid & (s3_step_ff.emit_a | s3_step_ff.emit_b);
   end

endmodule

// File: sv/bfm_rsp_queue.sv
// ----------------------------------------------------------------------------
// bfm_rsp_queue
// Result queue: one entry per item with results, one or two results popped per entry.
// ----------------------------------------------------------------------------
module bfm_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  bfm_pkg::step_type       issue,
   input  logic                    entry_valid,
   input  bfm_pkg::rsp_entry_type  entry,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bfm_pkg::mean_vec_type   rsp_mean,
   output logic                    rsp_frame_last
);
   import bfm_pkg::*;

   localparam int PW = RSP_AW + 1;

   rsp_entry_type   entries_ff [RSP_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]   count_ff, count_in;
   logic            sub_ff, sub_in;

   rsp_entry_type   head;
   logic            issue_rsp;
   logic            show_b;
   logic            pop;
   logic            done;

   // The count reserves a slot at input acceptance for every item that will
   // produce results, so the pipeline ahead of the queue never has to wait.
   always_comb begin
      issue_rsp = issue.valid & (issue.emit_a | issue.emit_b);
      full      = (count_ff == PW'(RSP_DEPTH));
      rsp_valid = (wr_ptr_ff != rd_ptr_ff);
      head      = entries_ff[rd_ptr_ff[RSP_AW-1:0]];
      show_b    = sub_ff | !head.has_a;
      pop       = rsp_valid & !rsp_stall;
      done      = pop & (show_b | !head.has_b);

      rsp_mean       = show_b ? head.mean_b : head.mean_a;
      rsp_frame_last = show_b & head.last_b;

      wr_ptr_in = entry_valid ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = done ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + PW'(issue_rsp) - PW'(done);
      sub_in    = sub_ff;
      if (done) begin
         sub_in = 1'b0;
      end else if (pop) begin
         sub_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
      if (entry_valid) begin
         entries_ff[wr_ptr_ff[RSP_AW-1:0]] <= entry;
      end
   end

endmodule

// File: sv/box_filter_3x3_mean_top.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_top
// 3x3 mean filter over a raster pixel stream with edge replication.
// ----------------------------------------------------------------------------
// The block takes one item per clock while not stalled: a pixel or a drain
// tick. Pixels of a frame arrive in raster order; output row r is produced
// while row r+1 arrives, and after the last pixel one drain tick per column
// flushes the final row. Each item gives zero, one or two results; the item
// at the end of a row can give two, and since the result port moves at most
// one transfer per clock the input briefly stalls there when the queue fills.
// Results pass the s1, window and s3 registers and an eight-item queue that
// lets the input take new items while earlier results wait. After reset the
// line stores are cleared, one column per clock, and the input is stalled
// until all are cleared; register writes are taken meanwhile. The user must
// write registers only while no results are outstanding; it is not enforced.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean_top #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_CHANNELS = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [bfm_pkg::PIX_W-1:0]          req_sample_c0,
   input  logic [bfm_pkg::PIX_W-1:0]          req_sample_c1,
   input  logic [bfm_pkg::PIX_W-1:0]          req_sample_c2,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bfm_pkg::PIX_W-1:0]          rsp_mean_c0,
   output logic [bfm_pkg::PIX_W-1:0]          rsp_mean_c1,
   output logic [bfm_pkg::PIX_W-1:0]          rsp_mean_c2,
   output logic                               rsp_frame_last,
   input  logic                               csr_wr_en,
   input  logic [bfm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfm_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import bfm_pkg::*;

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int NCH = (MAX_CHANNELS < CH_NUM) ? MAX_CHANNELS : CH_NUM;
   localparam int XW  = (AW + 1 > CSR_DATA_W) ? AW + 1 : CSR_DATA_W;

   logic [CSR_DATA_W-1:0]   image_width_ff;
   logic [CSR_DATA_W-1:0]   image_height_ff;
   logic [1:0]              channel_count_ff;

   logic [XW-1:0]           width_eff;
   logic [AW-1:0]           width_last;
   logic [CSR_DATA_W-1:0]   height_eff;
   logic [ROW_W-1:0]        height_last;
   logic [1:0]              chan_use;

   logic [CH_NUM*PIX_W-1:0] px_all;
   logic [NCH*PIX_W-1:0]    issue_px;
   step_type                issue;
   logic [AW-1:0]           issue_addr;
   logic                    clear_en;
   logic [AW-1:0]           clear_addr;
   logic                    queue_full;
   step_type                win_step;
   logic [2:0][NCH-1:0][CSUM_W-1:0] win_sum;
   logic                    entry_valid;
   rsp_entry_type           entry;
   mean_vec_type            rsp_mean;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= CSR_DATA_W'(256);
         image_height_ff  <= CSR_DATA_W'(256);
         channel_count_ff <= 2'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wr_data;
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wr_data;
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // Register values outside the supported range are clamped into it.
   always_comb begin
      width_eff = XW'(image_width_ff);
      if (width_eff == '0) begin
         width_eff = XW'(1);
      end else if (width_eff > XW'(MAX_WIDTH)) begin
         width_eff = XW'(MAX_WIDTH);
      end
      width_last = AW'(width_eff - XW'(1));

      height_eff = image_height_ff;
      if (height_eff == '0) begin
         height_eff = CSR_DATA_W'(1);
      end else if (height_eff > CSR_DATA_W'(MAX_HEIGHT)) begin
         height_eff = CSR_DATA_W'(MAX_HEIGHT);
      end
      height_last = ROW_W'(height_eff - CSR_DATA_W'(1));

      chan_use = (channel_count_ff == 2'd0) ? 2'd1 : channel_count_ff;
      if ({1'b0, chan_use} > 3'(MAX_CHANNELS)) begin
         chan_use = 2'(MAX_CHANNELS);
      end
   end

   assign px_all   = {req_sample_c2, req_sample_c1, req_sample_c0};
   assign issue_px = px_all[NCH*PIX_W-1:0];

   bfm_seq #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_kind_type'(req_type)),
      .req_stall   (req_stall),
      .width_last  (width_last),
      .height_last (height_last),
      .queue_full  (queue_full),
      .issue       (issue),
      .issue_addr  (issue_addr),
      .clear_en    (clear_en),
      .clear_addr  (clear_addr)
   );

   bfm_line #(
      .MAX_WIDTH (MAX_WIDTH),
      .NCH       (NCH)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_addr (issue_addr),
      .issue_px   (issue_px),
      .clear_en   (clear_en),
      .clear_addr (clear_addr),
      .win_step   (win_step),
      .win_sum    (win_sum)
   );

   bfm_mean #(
      .NCH (NCH)
   ) u_mean (
      .clock       (clock),
      .reset       (reset),
      .win_step    (win_step),
      .win_sum     (win_sum),
      .chan_use    (chan_use),
      .entry_valid (entry_valid),
      .entry       (entry)
   );

   bfm_rsp_queue u_rsp_queue (
      .clock          (clock),
      .reset          (reset),
      .issue          (issue),
      .entry_valid    (entry_valid),
      .entry          (entry),
      .full           (queue_full),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean       (rsp_mean),
      .rsp_frame_last (rsp_frame_last)
   );

   assign rsp_mean_c0 = rsp_mean[0];
   assign rsp_mean_c1 = rsp_mean[1];
   assign rsp_mean_c2 = rsp_mean[2];

endmodule
